@@ src/lkvc_pkg.sv @@
// Shared constants, request codes and control structs for the LRU key-value cache.
`default_nettype none

package lkvc_pkg;

    localparam int ENTRIES   = 16;
    localparam int DATA_W    = 32;
    localparam int CAP_W     = 5;
    localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RANK_W    = IDX_W;
    localparam int CNT_W     = $clog2(ENTRIES + 1);
    localparam int CMP_W     = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    typedef struct packed {
        logic capture;
        logic commit;
    } lkvc_ctl_t;

    typedef struct packed {
        logic out_full;
    } lkvc_status_t;

endpackage

`default_nettype wire

@@ src/lkvc_ctrl.sv @@
// Controller state machine that sequences capture and commit of each request.
`default_nettype none

module lkvc_ctrl
    import lkvc_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_stall,
    input  wire logic         out_stall,
    input  wire lkvc_status_t status,
    output lkvc_ctl_t         ctl
);

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg;
    logic   in_stall_reg;
    logic   commit_ok;

    assign commit_ok   = !status.out_full || !out_stall;
    assign in_stall    = in_stall_reg;
    assign ctl.capture = in_valid && !in_stall_reg;
    assign ctl.commit  = (state_reg == ST_EXEC) && commit_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            in_stall_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg    <= ST_EXEC;
                        in_stall_reg <= 1'b1;
                    end
                end
                ST_EXEC:
                begin
                    if (commit_ok)
                    begin
                        state_reg    <= ST_IDLE;
                        in_stall_reg <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg    <= ST_IDLE;
                    in_stall_reg <= 1'b0;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ src/lkvc_dp.sv @@
// Datapath: entry storage, key match, victim and free slot search, recency update.
`default_nettype none

module lkvc_dp
    import lkvc_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_write,
    input  wire logic [CAP_W-1:0]         cfg_data,
    input  wire logic                     cmd,
    input  wire logic signed [DATA_W-1:0] key,
    input  wire logic signed [DATA_W-1:0] value,
    input  wire lkvc_ctl_t                ctl,
    output lkvc_status_t                  status,
    input  wire logic                     out_stall,
    output logic                          out_valid,
    output logic                          hit,
    output logic signed [DATA_W-1:0]      read_value,
    output logic                          evicted,
    output logic signed [DATA_W-1:0]      evicted_key
);

    logic [DATA_W-1:0] key_reg [ENTRIES];
    logic [DATA_W-1:0] val_reg [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;
    logic [RANK_W-1:0] rank_reg [ENTRIES];
    logic [CNT_W-1:0]  fill_reg;
    logic [CAP_W-1:0]  cap_reg;

    logic              req_cmd_reg;
    logic [DATA_W-1:0] req_key_reg;
    logic [DATA_W-1:0] req_value_reg;
    logic              req_hit_reg;
    logic              req_evict_reg;
    logic [IDX_W-1:0]  req_slot_reg;

    logic              out_valid_reg;
    logic              hit_reg;
    logic [DATA_W-1:0] read_value_reg;
    logic              evicted_reg;
    logic [DATA_W-1:0] evicted_key_reg;

    logic              hit_next;
    logic              evict_next;
    logic [IDX_W-1:0]  slot_next;
    logic [IDX_W-1:0]  match_idx;
    logic [IDX_W-1:0]  lru_idx;
    logic [IDX_W-1:0]  free_idx;
    logic              lru_found;
    logic              free_found;
    logic [CMP_W-1:0]  eff_cap;
    logic              full;
    logic [RANK_W-1:0] hit_rank;

    assign status.out_full = out_valid_reg;
    assign out_valid       = out_valid_reg;
    assign hit             = hit_reg;
    assign read_value      = read_value_reg;
    assign evicted         = evicted_reg;
    assign evicted_key     = evicted_key_reg;

    // Lookup on the incoming key; the stored state is stable while a request is open.
    always_comb
    begin
        hit_next   = 1'b0;
        match_idx  = '0;
        lru_found  = 1'b0;
        lru_idx    = '0;
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (!hit_next && valid_reg[i] && (key_reg[i] == key))
            begin
                hit_next  = 1'b1;
                match_idx = IDX_W'(i);
            end
            if (!lru_found && valid_reg[i] && (CNT_W'(rank_reg[i]) + CNT_W'(1) == fill_reg))
            begin
                lru_found = 1'b1;
                lru_idx   = IDX_W'(i);
            end
            if (!free_found && !valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
        if (cap_reg == '0)
        begin
            eff_cap = CMP_W'(1);
        end
        else if (CMP_W'(cap_reg) > CMP_W'(ENTRIES))
        begin
            eff_cap = CMP_W'(ENTRIES);
        end
        else
        begin
            eff_cap = CMP_W'(cap_reg);
        end
        full       = (CMP_W'(fill_reg) >= eff_cap) && lru_found;
        evict_next = (cmd == CMD_PUT) && !hit_next && full;
        if (hit_next)
        begin
            slot_next = match_idx;
        end
        else if (evict_next)
        begin
            slot_next = lru_idx;
        end
        else
        begin
            slot_next = free_idx;
        end
    end

    assign hit_rank = rank_reg[req_slot_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_write)
        begin
            cap_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            req_cmd_reg   <= cmd;
            req_key_reg   <= key;
            req_value_reg <= value;
            req_hit_reg   <= hit_next;
            req_evict_reg <= evict_next;
            req_slot_reg  <= slot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.commit && (req_cmd_reg == CMD_PUT))
        begin
            val_reg[req_slot_reg] <= req_value_reg;
            if (!req_hit_reg)
            begin
                key_reg[req_slot_reg] <= req_key_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            fill_reg  <= '0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else if (ctl.commit)
        begin
            if (req_hit_reg)
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (IDX_W'(i) == req_slot_reg)
                    begin
                        rank_reg[i] <= '0;
                    end
                    else if (valid_reg[i] && (rank_reg[i] < hit_rank))
                    begin
                        rank_reg[i] <= rank_reg[i] + RANK_W'(1);
                    end
                end
            end
            else if (req_cmd_reg == CMD_PUT)
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (IDX_W'(i) == req_slot_reg)
                    begin
                        rank_reg[i] <= '0;
                    end
                    else if (valid_reg[i])
                    begin
                        rank_reg[i] <= rank_reg[i] + RANK_W'(1);
                    end
                end
                valid_reg[req_slot_reg] <= 1'b1;
                if (!req_evict_reg)
                begin
                    fill_reg <= fill_reg + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.commit)
        begin
            hit_reg     <= req_hit_reg;
            evicted_reg <= req_evict_reg;
            if (req_hit_reg && (req_cmd_reg == CMD_GET))
            begin
                read_value_reg <= val_reg[req_slot_reg];
            end
            else
            begin
                read_value_reg <= '0;
            end
            if (req_evict_reg)
            begin
                evicted_key_reg <= key_reg[req_slot_reg];
            end
            else
            begin
                evicted_key_reg <= '0;
            end
        end
    end

endmodule

`default_nettype wire

@@ src/lru_key_value_cache.sv @@
// Top level of the fully associative key-value cache with LRU replacement.
//
// Requests arrive on in_valid/in_stall with cmd (get or put), key and value.
// Each accepted item yields exactly one result on out_valid/out_stall with
// hit, read_value, evicted and evicted_key, in request order.
// A get hit returns the stored value and makes the entry most recent; a put
// updates an existing key or inserts a new one, evicting the least recent
// entry when the configured capacity is reached.
// An item is accepted while its key is compared against all entries and the
// victim or free slot is chosen, then committed in the execute state with the
// recency update. The compare and the recency update are the two steps.
// One item is in flight at a time; the next can be accepted while a finished
// result waits in the output register.
// If the receiver stalls, the result holds and the commit of the next item
// waits, so in_stall stays high until the output register frees.
// Reset empties the cache and sets the capacity to 16. The capacity register
// is written through cfg_write and cfg_data; the user must write it only while
// the block is idle, since the block itself does not enforce this.
`default_nettype none

module lru_key_value_cache
    import lkvc_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_write,
    input  wire logic [CAP_W-1:0]         cfg_data,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic                     cmd,
    input  wire logic signed [DATA_W-1:0] key,
    input  wire logic signed [DATA_W-1:0] value,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic                          hit,
    output logic signed [DATA_W-1:0]      read_value,
    output logic                          evicted,
    output logic signed [DATA_W-1:0]      evicted_key
);

    lkvc_ctl_t    ctl;
    lkvc_status_t status;

    lkvc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_stall (out_stall),
        .status    (status),
        .ctl       (ctl)
    );

    lkvc_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .key         (key),
        .value       (value),
        .ctl         (ctl),
        .status      (status),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .hit         (hit),
        .read_value  (read_value),
        .evicted     (evicted),
        .evicted_key (evicted_key)
    );

endmodule

`default_nettype wire

@@ src/lkvc_checker.sv @@
// Port-level checker for the LRU key-value cache and its bind to the top level.
`default_nettype none

module lkvc_checker
    import lkvc_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_stall,
    input wire logic              out_valid,
    input wire logic              out_stall,
    input wire logic              hit,
    input wire logic [DATA_W-1:0] read_value,
    input wire logic              evicted,
    input wire logic [DATA_W-1:0] evicted_key
);

    // A stalled result must hold until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(read_value)
            && $stable(evicted_key) && $stable(hit) && $stable(evicted))
        else $error("stalled result changed");

    // Only one item is open at a time.
    a_one_open: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("item accepted while another is open");

    // A put that finds its key never evicts.
    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(hit && evicted))
        else $error("hit and eviction reported together");

    // Fields without meaning for the result are zero.
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (hit || read_value == '0) && (evicted || evicted_key == '0))
        else $error("unused result field not zero");

    // A fresh result follows an accepted item that was still open.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without an open item");

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .hit         (hit),
    .read_value  (read_value),
    .evicted     (evicted),
    .evicted_key (evicted_key)
);

`default_nettype wire

@@ sim/lru_key_value_cache_tb.sv @@
// Self-checking testbench for the LRU key-value cache: directed cases, random traffic, back-pressure.
module lru_key_value_cache_tb
    import lkvc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int KEY_POOL_SIZE = 24;

    typedef struct packed {
        logic                     hit;
        logic signed [DATA_W-1:0] read_value;
        logic                     evicted;
        logic signed [DATA_W-1:0] evicted_key;
    } lookup_result_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_write = 1'b0;
    logic [CAP_W-1:0]         cfg_data = '0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic                     cmd = CMD_GET;
    logic signed [DATA_W-1:0] key = '0;
    logic signed [DATA_W-1:0] value = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic                     hit;
    logic signed [DATA_W-1:0] read_value;
    logic                     evicted;
    logic signed [DATA_W-1:0] evicted_key;

    lookup_result_t expected_q[$];
    int error_count = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_cycles_req = 0;
    int hold_count = 0;

    // Shadow copy of the cache contents used to predict each result.
    logic signed [DATA_W-1:0] shadow_key [ENTRIES];
    logic signed [DATA_W-1:0] shadow_value [ENTRIES];
    logic                     shadow_valid [ENTRIES];
    int                       shadow_rank [ENTRIES];
    int                       shadow_fill = 0;
    logic [CAP_W-1:0]         shadow_capacity = CAP_RESET;
    logic signed [DATA_W-1:0] key_pool [KEY_POOL_SIZE];

    lru_key_value_cache u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .key         (key),
        .value       (value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .hit         (hit),
        .read_value  (read_value),
        .evicted     (evicted),
        .evicted_key (evicted_key)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (hold_count < hold_cycles_req)
        begin
            hold_count <= hold_count + 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        lookup_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result hit=%0b read_value=%0d", $time, hit, read_value);
                error_count++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (hit !== want.hit)
                begin
                    $display("%0t: hit expected %0b actual %0b", $time, want.hit, hit);
                    error_count++;
                end
                if (read_value !== want.read_value)
                begin
                    $display("%0t: read_value expected %0d actual %0d",
                             $time, want.read_value, read_value);
                    error_count++;
                end
                if (evicted !== want.evicted)
                begin
                    $display("%0t: evicted expected %0b actual %0b", $time, want.evicted, evicted);
                    error_count++;
                end
                if (evicted_key !== want.evicted_key)
                begin
                    $display("%0t: evicted_key expected %0d actual %0d",
                             $time, want.evicted_key, evicted_key);
                    error_count++;
                end
            end
        end
    end

    function automatic void make_recent(int slot);
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (shadow_valid[i] && i != slot && shadow_rank[i] < shadow_rank[slot])
                shadow_rank[i]++;
        end
        shadow_rank[slot] = 0;
    endfunction

    function automatic lookup_result_t predict_lookup(logic req_cmd,
                                                      logic signed [DATA_W-1:0] req_key,
                                                      logic signed [DATA_W-1:0] req_value);
        lookup_result_t r;
        int found;
        int slot;
        int cap_limit;
        r = '0;
        found = -1;
        slot = -1;
        cap_limit = (shadow_capacity < 1) ? 1 :
                    (shadow_capacity > ENTRIES) ? ENTRIES : int'(shadow_capacity);
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (found < 0 && shadow_valid[i] && shadow_key[i] == req_key)
                found = i;
        end
        if (found >= 0)
        begin
            r.hit = 1'b1;
            if (req_cmd == CMD_GET)
                r.read_value = shadow_value[found];
            else
                shadow_value[found] = req_value;
            make_recent(found);
        end
        else if (req_cmd == CMD_PUT)
        begin
            if (shadow_fill >= cap_limit)
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (shadow_valid[i] && (slot < 0 || shadow_rank[i] > shadow_rank[slot]))
                        slot = i;
                end
                if (slot >= 0)
                begin
                    r.evicted = 1'b1;
                    r.evicted_key = shadow_key[slot];
                    shadow_valid[slot] = 1'b0;
                    shadow_fill--;
                end
            end
            if (slot < 0)
            begin
                for (int i = ENTRIES - 1; i >= 0; i--)
                begin
                    if (!shadow_valid[i])
                        slot = i;
                end
            end
            if (slot >= 0)
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (shadow_valid[i])
                        shadow_rank[i]++;
                end
                shadow_key[slot] = req_key;
                shadow_value[slot] = req_value;
                shadow_valid[slot] = 1'b1;
                shadow_rank[slot] = 0;
                shadow_fill++;
            end
        end
        return r;
    endfunction

    task automatic send_request(input logic req_cmd, input logic signed [DATA_W-1:0] req_key,
                                input logic signed [DATA_W-1:0] req_value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= req_cmd;
        key <= req_key;
        value <= req_value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_q.push_back(predict_lookup(req_cmd, req_key, req_value));
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] cap);
        wait_idle();
        cfg_data <= cap;
        cfg_write <= 1'b1;
        @(posedge clk);
        shadow_capacity = cap;
        cfg_write <= 1'b0;
    endtask

    task automatic send_random_item();
        logic signed [DATA_W-1:0] k;
        if ($urandom_range(99) < 85)
            k = key_pool[$urandom_range(KEY_POOL_SIZE - 1)];
        else
            k = $urandom;
        send_request($urandom_range(1) ? CMD_PUT : CMD_GET, k, $urandom);
    endtask

    task automatic test_empty_gets();
        send_request(CMD_GET, 32'sh0000_0000, 32'sh7FFF_FFFF);
        send_request(CMD_GET, 32'sh8000_0000, 32'sh0000_0000);
        send_request(CMD_GET, 32'sh7FFF_FFFF, 32'sh8000_0000);
    endtask

    task automatic test_put_get();
        send_request(CMD_PUT, 32'sh8000_0000, 32'sh7FFF_FFFF);
        send_request(CMD_PUT, 32'sh7FFF_FFFF, 32'sh8000_0000);
        send_request(CMD_GET, 32'sh8000_0000, 32'sh0000_0000);
        send_request(CMD_PUT, 32'sh7FFF_FFFF, 32'shFFFF_FFFF);
        send_request(CMD_GET, 32'sh7FFF_FFFF, 32'sh1234_5678);
        send_request(CMD_GET, 32'shFFFF_FFFF, 32'sh0000_0000);
    endtask

    task automatic test_capacity_one();
        set_capacity(5'd0);
        send_request(CMD_PUT, 32'sh0000_0011, 32'sh0000_0101);
        send_request(CMD_PUT, 32'sh0000_0022, 32'sh0000_0202);
        send_request(CMD_GET, 32'sh0000_0011, 32'sh0000_0000);
        send_request(CMD_GET, 32'sh0000_0022, 32'sh0000_0000);
        set_capacity(5'd1);
        send_request(CMD_PUT, 32'sh0000_0033, 32'sh0000_0303);
    endtask

    task automatic test_capacity_shrink();
        set_capacity(5'd4);
        send_request(CMD_PUT, 32'sh0000_0044, 32'sh0000_0404);
        send_request(CMD_PUT, 32'sh0000_0055, 32'sh0000_0505);
        send_request(CMD_GET, 32'sh0000_0033, 32'sh0000_0000);
        send_request(CMD_PUT, 32'sh0000_0066, 32'sh0000_0606);
        set_capacity(5'd2);
        send_request(CMD_PUT, 32'sh0000_0077, 32'sh0000_0707);
        send_request(CMD_PUT, 32'sh0000_0088, 32'sh0000_0808);
        send_request(CMD_GET, 32'sh0000_0033, 32'sh0000_0000);
    endtask

    task automatic test_back_pressure();
        set_capacity(5'd8);
        send_idle_pct = 0;
        stall_pct = 0;
        hold_cycles_req = hold_count + 300;
        repeat (40) send_random_item();
    endtask

    task automatic run_phase(input int items, input int idle_pct, input int stall,
                             input logic [CAP_W-1:0] cap);
        set_capacity(cap);
        send_idle_pct = idle_pct;
        stall_pct = stall;
        repeat (items) send_random_item();
    endtask

    task automatic test_random_traffic();
        run_phase(170, 0, 0, 5'd16);
        run_phase(170, 87, 0, 5'd3);
        run_phase(170, 0, 87, 5'd31);
        run_phase(170, 16, 16, 5'd1);
        run_phase(130, 0, 0, 5'($urandom_range(31)));
    endtask

    initial
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            shadow_key[i] = '0;
            shadow_value[i] = '0;
            shadow_valid[i] = 1'b0;
            shadow_rank[i] = 0;
        end
        for (int i = 0; i < KEY_POOL_SIZE; i++)
            key_pool[i] = $urandom;
        key_pool[0] = 32'sh8000_0000;
        key_pool[1] = 32'sh7FFF_FFFF;
        key_pool[2] = 32'sh0000_0000;
        key_pool[3] = 32'shFFFF_FFFF;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_gets();
        test_put_get();
        test_capacity_one();
        test_capacity_shrink();
        test_back_pressure();
        test_random_traffic();

        wait_idle();
        repeat (10) @(posedge clk);
        if (error_count == 0 && expected_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
